@@ src/triangle_surface_frame_core_defines.svh @@
// Assertion macros shared by the RTL. Compiled out when SYNTHESIS is set.
`ifndef TRIANGLE_SURFACE_FRAME_CORE_DEFINES_SVH
`define TRIANGLE_SURFACE_FRAME_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TSF_ASSERT(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("tsf assertion failed");
`define TSF_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tsf implication failed");
`else
`define TSF_ASSERT(lbl, cond)
`define TSF_ASSERT_IMP(lbl, pre, post)
`endif

`endif

@@ src/tsf_pkg.sv @@
`default_nettype none
package tsf_pkg;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_DET   = 2'd2,
      ST_ZERO  = 2'd3
   } status_type;

   localparam int LANE_BITS  = 16;
   localparam int LANE_FRAC  = 14;
   localparam int LANE_ONE   = 1 << LANE_FRAC;
   localparam int NORM_BITS  = 30;           // normalised magnitude width
   localparam int SQ_BITS    = 64;           // root working width
   localparam int ROOT_STEPS = 32;           // one root bit per stage
   localparam int ROOT_BITS  = 32;
   localparam int QUOT_BITS  = LANE_FRAC + 1;
   localparam int NUM_BITS   = NORM_BITS + QUOT_BITS + 3;
   localparam int DEN_BITS   = ROOT_BITS + 1;
   localparam int UV_BITS    = 16;
   localparam int UVD_BITS   = UV_BITS + 1;
   localparam int POS_BITS   = 48;
   localparam int TEX_BITS   = 32;
   localparam int IDX_BITS   = 10;
   localparam int VC_BITS    = 11;
   localparam int VEC_BITS   = 3 * LANE_BITS;

   // register stages inside tsf_unit, input to packed result
   localparam int UNIT_LAT   = 6 + ROOT_STEPS + 1 + QUOT_BITS + 1;

endpackage
`default_nettype wire

@@ src/tsf_ram.sv @@
`default_nettype none
module tsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

@@ src/tsf_unit.sv @@
`default_nettype none
// Pipelined vector normaliser: abs, max, length, shift, squares, root, divide.
module tsf_unit #(
   parameter int VW = 36
) (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic signed [VW-1:0]              vec_x,
   input  wire logic signed [VW-1:0]              vec_y,
   input  wire logic signed [VW-1:0]              vec_z,
   output logic             [tsf_pkg::VEC_BITS-1:0] packed_out,
   output logic                                   nz_out
);
   import tsf_pkg::*;

   localparam int LW = $clog2(VW + 1);
   localparam int XW = VW + NORM_BITS;

   logic signed [VW-1:0] vin [3];
   assign vin[0] = vec_x;
   assign vin[1] = vec_y;
   assign vin[2] = vec_z;

   logic [VW-1:0]        mag_a_ff [3];
   logic [2:0]           sgn_a_ff;
   logic [VW-1:0]        mag_b_ff [3];
   logic [2:0]           sgn_b_ff;
   logic [VW-1:0]        mx_b_ff;
   logic [VW-1:0]        mx_b_in;
   logic [VW-1:0]        mag_c_ff [3];
   logic [2:0]           sgn_c_ff;
   logic [LW-1:0]        len_c_ff;
   logic [LW-1:0]        len_c_in;
   logic [NORM_BITS-1:0] nm_d_ff [3];
   logic [NORM_BITS-1:0] nm_d_in [3];
   logic [2:0]           sgn_d_ff;
   logic                 nz_d_ff;
   logic [2*NORM_BITS-1:0] sq_e_ff [3];
   logic [NORM_BITS-1:0] nm_e_ff [3];
   logic [2:0]           sgn_e_ff;
   logic                 nz_e_ff;

   // root pipeline, index 0 is the sum stage
   logic [SQ_BITS-1:0]   rx_ff [ROOT_STEPS+1];
   logic [SQ_BITS-1:0]   rr_ff [ROOT_STEPS+1];
   logic [NORM_BITS-1:0] nm_r_ff [ROOT_STEPS+1][3];
   logic [2:0]           sgn_r_ff [ROOT_STEPS+1];
   logic                 nz_r_ff [ROOT_STEPS+1];

   // divider pipeline, index 0 is the set-up stage
   logic [NUM_BITS-1:0]  nn_ff [QUOT_BITS+1][3];
   logic [QUOT_BITS-1:0] qq_ff [QUOT_BITS+1][3];
   logic [DEN_BITS-1:0]  dd_ff [QUOT_BITS+1];
   logic [2:0]           sgn_q_ff [QUOT_BITS+1];
   logic                 nz_q_ff [QUOT_BITS+1];

   logic [ROOT_BITS-1:0] norm;
   assign norm = rr_ff[ROOT_STEPS][ROOT_BITS-1:0];

   always_comb begin
      mx_b_in = mag_a_ff[0];
      if (mag_a_ff[1] > mx_b_in) begin
         mx_b_in = mag_a_ff[1];
      end
      if (mag_a_ff[2] > mx_b_in) begin
         mx_b_in = mag_a_ff[2];
      end
   end

   always_comb begin
      len_c_in = '0;
      for (int i = 0; i < VW; i++) begin
         if (mx_b_ff[i]) begin
            len_c_in = LW'(i + 1);
         end
      end
   end

   always_comb begin
      logic [XW-1:0] wide;
      for (int k = 0; k < 3; k++) begin
         wide = XW'(mag_c_ff[k]);
         if (32'(len_c_ff) > NORM_BITS) begin
            wide = wide >> (32'(len_c_ff) - NORM_BITS);
         end else begin
            wide = wide << (NORM_BITS - 32'(len_c_ff));
         end
         nm_d_in[k] = wide[NORM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            mag_a_ff[k] <= vin[k][VW-1] ? VW'(-vin[k]) : VW'(vin[k]);
            sgn_a_ff[k] <= vin[k][VW-1];
            mag_b_ff[k] <= mag_a_ff[k];
            mag_c_ff[k] <= mag_b_ff[k];
            nm_d_ff[k]  <= nm_d_in[k];
            sq_e_ff[k]  <= (2*NORM_BITS)'(nm_d_ff[k]) * (2*NORM_BITS)'(nm_d_ff[k]);
            nm_e_ff[k]  <= nm_d_ff[k];
            nm_r_ff[0][k] <= nm_e_ff[k];
         end
         sgn_b_ff <= sgn_a_ff;
         mx_b_ff  <= mx_b_in;
         sgn_c_ff <= sgn_b_ff;
         len_c_ff <= len_c_in;
         sgn_d_ff <= sgn_c_ff;
         nz_d_ff  <= (len_c_ff != '0);
         sgn_e_ff <= sgn_d_ff;
         nz_e_ff  <= nz_d_ff;

         rx_ff[0]    <= SQ_BITS'(sq_e_ff[0]) + SQ_BITS'(sq_e_ff[1]) + SQ_BITS'(sq_e_ff[2]);
         rr_ff[0]    <= '0;
         sgn_r_ff[0] <= sgn_e_ff;
         nz_r_ff[0]  <= nz_e_ff;

         // one root digit per stage
         for (int j = 0; j < ROOT_STEPS; j++) begin
            if (rx_ff[j] >= rr_ff[j] + (SQ_BITS'(1) << (2 * (ROOT_STEPS - 1 - j)))) begin
               rx_ff[j+1] <= rx_ff[j] - (rr_ff[j] + (SQ_BITS'(1) << (2 * (ROOT_STEPS - 1 - j))));
               rr_ff[j+1] <= (rr_ff[j] >> 1) + (SQ_BITS'(1) << (2 * (ROOT_STEPS - 1 - j)));
            end else begin
               rx_ff[j+1] <= rx_ff[j];
               rr_ff[j+1] <= rr_ff[j] >> 1;
            end
            for (int k = 0; k < 3; k++) begin
               nm_r_ff[j+1][k] <= nm_r_ff[j][k];
            end
            sgn_r_ff[j+1] <= sgn_r_ff[j];
            nz_r_ff[j+1]  <= nz_r_ff[j];
         end

         // q = (m * 2^15 + norm) / (2 * norm), rounds half away
         for (int k = 0; k < 3; k++) begin
            nn_ff[0][k] <= (NUM_BITS'(nm_r_ff[ROOT_STEPS][k]) << QUOT_BITS) + NUM_BITS'(norm);
            qq_ff[0][k] <= '0;
         end
         dd_ff[0]    <= DEN_BITS'(norm) << 1;
         sgn_q_ff[0] <= sgn_r_ff[ROOT_STEPS];
         nz_q_ff[0]  <= nz_r_ff[ROOT_STEPS];

         for (int i = 0; i < QUOT_BITS; i++) begin
            for (int k = 0; k < 3; k++) begin
               if (nn_ff[i][k] >= (NUM_BITS'(dd_ff[i]) << (QUOT_BITS - 1 - i))) begin
                  nn_ff[i+1][k] <= nn_ff[i][k] - (NUM_BITS'(dd_ff[i]) << (QUOT_BITS - 1 - i));
                  qq_ff[i+1][k] <= qq_ff[i][k] | (QUOT_BITS'(1) << (QUOT_BITS - 1 - i));
               end else begin
                  nn_ff[i+1][k] <= nn_ff[i][k];
                  qq_ff[i+1][k] <= qq_ff[i][k];
               end
            end
            dd_ff[i+1]    <= dd_ff[i];
            sgn_q_ff[i+1] <= sgn_q_ff[i];
            nz_q_ff[i+1]  <= nz_q_ff[i];
         end

         for (int k = 0; k < 3; k++) begin
            logic [LANE_BITS-1:0] q;
            q = LANE_BITS'(qq_ff[QUOT_BITS][k]);
            if (q > LANE_BITS'(LANE_ONE)) begin
               q = LANE_BITS'(LANE_ONE);
            end
            packed_out[k*LANE_BITS +: LANE_BITS] <= sgn_q_ff[QUOT_BITS][k] ? -q : q;
         end
         nz_out <= nz_q_ff[QUOT_BITS];
      end
   end
endmodule
`default_nettype wire

@@ src/triangle_surface_frame_core.sv @@
`default_nettype none
`include "triangle_surface_frame_core_defines.svh"
// Channel  Dir  tdata / data                         tuser
// req      in   index_a,index_b,index_c,pos,uv (112)  func
// rsp      out  normal,tangent,bitangent (144)        status
// csr      in   vertex_count (11)                     -
//
// One item per cycle while no result is held at the output; each item passes
// 4 front stages, 55 normaliser stages and 1 output register. The normaliser
// depth is set by the 32-step root and 15-step divider.
// A vertex written at one edge is seen by a triangle accepted at the next.
// Whole pipe advances together; a held result stalls the input side.
// Synchronous reset clears valids and vertex_count; stores are not cleared.
module triangle_surface_frame_core #(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [111:0] req_tdata,  // index_a, index_b, index_c, vertex_position, vertex_uv
   input  wire logic         req_tuser,  // func
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [143:0] rsp_tdata,  // normal_out, tangent_out, bitangent_out
   output logic      [1:0]   rsp_tuser,  // status
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [tsf_pkg::VC_BITS-1:0] csr_data  // vertex_count
);
   import tsf_pkg::*;

   localparam int AW  = $clog2(MAX_VERTICES);
   localparam int C   = COORD_BITS;
   localparam int EW  = C + 1;
   localparam int PW  = 2 * EW;
   localparam int NW  = PW + 1;
   localparam int TPW = EW + UVD_BITS;
   localparam int TW  = TPW + 1;
   localparam int VW  = (NW > TW) ? NW : TW;
   localparam int RW  = POS_BITS + TEX_BITS;
   localparam int DW  = 2 * UVD_BITS;

   logic adv;
   logic req_acc;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign req_acc    = req_tvalid && adv;
   assign csr_ready  = 1'b1;

   logic [IDX_BITS-1:0] idx_a, idx_b, idx_c;
   logic [POS_BITS-1:0] vpos;
   logic [TEX_BITS-1:0] vuv;
   assign idx_a = req_tdata[9:0];
   assign idx_b = req_tdata[19:10];
   assign idx_c = req_tdata[29:20];
   assign vpos  = req_tdata[77:30];
   assign vuv   = req_tdata[109:78];

   logic [VC_BITS-1:0] vcount_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         vcount_ff <= csr_data;
      end
   end

   // triangles check indices against vertex count and store depth; writes check store depth only
   logic a_ok, b_ok, c_ok, wr_ok, bad_in;
   assign a_ok  = 32'(idx_a) < 32'(vcount_ff) && 32'(idx_a) < MAX_VERTICES;
   assign b_ok  = 32'(idx_b) < 32'(vcount_ff) && 32'(idx_b) < MAX_VERTICES;
   assign c_ok  = 32'(idx_c) < 32'(vcount_ff) && 32'(idx_c) < MAX_VERTICES;
   assign wr_ok = 32'(idx_a) < MAX_VERTICES;
   assign bad_in = req_tuser ? !(a_ok && b_ok && c_ok) : !wr_ok;

   // three copies of the vertex store, one read port each
   logic [RW-1:0] rd_a, rd_b, rd_c;
   logic          wr_en;
   assign wr_en = req_acc && !req_tuser && wr_ok;

   tsf_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_ram_a (
      .clock(clock), .wr_en(wr_en), .wr_addr(AW'(idx_a)), .wr_data({vuv, vpos}),
      .rd_en(adv), .rd_addr(AW'(idx_a)), .rd_data(rd_a));
   tsf_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_ram_b (
      .clock(clock), .wr_en(wr_en), .wr_addr(AW'(idx_a)), .wr_data({vuv, vpos}),
      .rd_en(adv), .rd_addr(AW'(idx_b)), .rd_data(rd_b));
   tsf_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_ram_c (
      .clock(clock), .wr_en(wr_en), .wr_addr(AW'(idx_a)), .wr_data({vuv, vpos}),
      .rd_en(adv), .rd_addr(AW'(idx_c)), .rd_data(rd_c));

   // control lines for stages 1..4
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic f1_ff, f2_ff, f3_ff, f4_ff;
   logic b1_ff, b2_ff, b3_ff, b4_ff;

   // stage 2: edges and uv deltas
   logic [3*C-1:0] pa, pb, pc;
   assign pa = (3*C)'(rd_a[POS_BITS-1:0]);
   assign pb = (3*C)'(rd_b[POS_BITS-1:0]);
   assign pc = (3*C)'(rd_c[POS_BITS-1:0]);

   logic signed [EW-1:0]       e1_ff [3], e2_ff [3];
   logic signed [UVD_BITS-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;

   // stage 3: products
   logic signed [PW-1:0]         pn_ff [6];
   logic signed [DW-1:0]         pd1_ff, pd2_ff;
   logic signed [TPW-1:0]        t1_ff [3], t2_ff [3], b1p_ff [3], b2p_ff [3];

   // stage 4: vectors
   logic signed [VW-1:0] nv_ff [3], tv_ff [3], bv_ff [3];
   logic                 detz4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff <= req_tuser;
         b1_ff <= bad_in;
         f2_ff <= f1_ff;  b2_ff <= b1_ff;
         f3_ff <= f2_ff;  b3_ff <= b2_ff;
         f4_ff <= f3_ff;  b4_ff <= b3_ff;

         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= EW'($signed(pb[k*C +: C])) - EW'($signed(pa[k*C +: C]));
            e2_ff[k] <= EW'($signed(pc[k*C +: C])) - EW'($signed(pa[k*C +: C]));
         end
         du1_ff <= UVD_BITS'($signed(rd_b[POS_BITS +: UV_BITS]))
                 - UVD_BITS'($signed(rd_a[POS_BITS +: UV_BITS]));
         dv1_ff <= UVD_BITS'($signed(rd_b[POS_BITS+UV_BITS +: UV_BITS]))
                 - UVD_BITS'($signed(rd_a[POS_BITS+UV_BITS +: UV_BITS]));
         du2_ff <= UVD_BITS'($signed(rd_c[POS_BITS +: UV_BITS]))
                 - UVD_BITS'($signed(rd_a[POS_BITS +: UV_BITS]));
         dv2_ff <= UVD_BITS'($signed(rd_c[POS_BITS+UV_BITS +: UV_BITS]))
                 - UVD_BITS'($signed(rd_a[POS_BITS+UV_BITS +: UV_BITS]));

         pn_ff[0] <= PW'(e1_ff[1]) * PW'(e2_ff[2]);
         pn_ff[1] <= PW'(e1_ff[2]) * PW'(e2_ff[1]);
         pn_ff[2] <= PW'(e1_ff[2]) * PW'(e2_ff[0]);
         pn_ff[3] <= PW'(e1_ff[0]) * PW'(e2_ff[2]);
         pn_ff[4] <= PW'(e1_ff[0]) * PW'(e2_ff[1]);
         pn_ff[5] <= PW'(e1_ff[1]) * PW'(e2_ff[0]);
         pd1_ff   <= DW'(du1_ff) * DW'(dv2_ff);
         pd2_ff   <= DW'(dv1_ff) * DW'(du2_ff);
         for (int k = 0; k < 3; k++) begin
            t1_ff[k]  <= TPW'(e1_ff[k]) * TPW'(dv2_ff);
            t2_ff[k]  <= TPW'(e2_ff[k]) * TPW'(dv1_ff);
            b1p_ff[k] <= TPW'(e2_ff[k]) * TPW'(du1_ff);
            b2p_ff[k] <= TPW'(e1_ff[k]) * TPW'(du2_ff);
         end

         // det > 0 flips tangent and bitangent (the -1/det sign)
         nv_ff[0] <= VW'(pn_ff[0]) - VW'(pn_ff[1]);
         nv_ff[1] <= VW'(pn_ff[2]) - VW'(pn_ff[3]);
         nv_ff[2] <= VW'(pn_ff[4]) - VW'(pn_ff[5]);
         for (int k = 0; k < 3; k++) begin
            if (pd1_ff > pd2_ff) begin
               tv_ff[k] <= VW'(t2_ff[k]) - VW'(t1_ff[k]);
               bv_ff[k] <= VW'(b2p_ff[k]) - VW'(b1p_ff[k]);
            end else begin
               tv_ff[k] <= VW'(t1_ff[k]) - VW'(t2_ff[k]);
               bv_ff[k] <= VW'(b1p_ff[k]) - VW'(b2p_ff[k]);
            end
         end
         detz4_ff <= (pd1_ff == pd2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // normalisers
   logic [VEC_BITS-1:0] n_pk, t_pk, b_pk;
   logic                n_nz, t_nz, b_nz;

   tsf_unit #(.VW(VW)) u_norm_n (
      .clock(clock), .en(adv), .vec_x(nv_ff[0]), .vec_y(nv_ff[1]), .vec_z(nv_ff[2]),
      .packed_out(n_pk), .nz_out(n_nz));
   tsf_unit #(.VW(VW)) u_norm_t (
      .clock(clock), .en(adv), .vec_x(tv_ff[0]), .vec_y(tv_ff[1]), .vec_z(tv_ff[2]),
      .packed_out(t_pk), .nz_out(t_nz));
   tsf_unit #(.VW(VW)) u_norm_b (
      .clock(clock), .en(adv), .vec_x(bv_ff[0]), .vec_y(bv_ff[1]), .vec_z(bv_ff[2]),
      .packed_out(b_pk), .nz_out(b_nz));

   // control delay matching the normaliser depth
   logic dv_ff [UNIT_LAT];
   logic df_ff [UNIT_LAT];
   logic db_ff [UNIT_LAT];
   logic dz_ff [UNIT_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         df_ff[0] <= f4_ff;
         db_ff[0] <= b4_ff;
         dz_ff[0] <= detz4_ff;
         for (int i = 1; i < UNIT_LAT; i++) begin
            df_ff[i] <= df_ff[i-1];
            db_ff[i] <= db_ff[i-1];
            dz_ff[i] <= dz_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < UNIT_LAT; i++) begin
            dv_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         dv_ff[0] <= v4_ff;
         for (int i = 1; i < UNIT_LAT; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
      end
   end

   // result selection
   status_type st_in;
   always_comb begin
      if (db_ff[UNIT_LAT-1]) begin
         st_in = ST_RANGE;
      end else if (!df_ff[UNIT_LAT-1]) begin
         st_in = ST_OK;
      end else if (!n_nz) begin
         st_in = ST_ZERO;
      end else if (dz_ff[UNIT_LAT-1]) begin
         st_in = ST_DET;
      end else if (!t_nz || !b_nz) begin
         st_in = ST_ZERO;
      end else begin
         st_in = ST_OK;
      end
   end

   logic                vec_on;
   assign vec_on = df_ff[UNIT_LAT-1] && (st_in == ST_OK);

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [143:0]       rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_ff[UNIT_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_status_ff <= st_in;
         rsp_data_ff   <= vec_on ? {b_pk, t_pk, n_pk} : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   // good item showing a bitangent
   logic ok_bitan;
   assign ok_bitan = rsp_tvalid && rsp_tuser == ST_OK && rsp_tdata[143:96] != '0;

   // a held result must hold off new items
   `TSF_ASSERT_IMP(a_stall_blocks, rsp_tvalid && !rsp_tready, !req_tready)
   // failed items carry no vectors
   `TSF_ASSERT_IMP(a_fail_zero, rsp_tvalid && rsp_tuser != ST_OK, rsp_tdata == '0)
   // a good triangle has a non-zero unit normal
   `TSF_ASSERT(a_ok_normal, !ok_bitan || rsp_tdata[47:0] != '0)
endmodule
`default_nettype wire
